// ===== rtl/linear_sensor_readout_sequencer_top_macros.svh =====
// ------------------------------------------------------------------------
// linear sensor readout sequencer assertion macros
// Shared assertion wrappers; they compile to nothing under synthesis.
// ------------------------------------------------------------------------
`ifndef LINEAR_SENSOR_READOUT_SEQUENCER_TOP_MACROS_SVH
`define LINEAR_SENSOR_READOUT_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define LSRS_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsrs assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define LSRS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsrs assertion failed");
`else
`define LSRS_ASSERT_NOW(name, ante, cons)
`define LSRS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/lsrs_pkg.sv =====
// ------------------------------------------------------------------------
// lsrs_pkg
// Types and constants of the linear sensor readout sequencer.
// ------------------------------------------------------------------------
package lsrs_pkg;

	// sample and scan geometry
	localparam int SAMPLE_BITS = 10;
	localparam int MAX_PIXELS  = 1024;

	// field widths
	localparam int PIX_VAL_W = 10;
	localparam int PIX_IDX_W = $clog2(MAX_PIXELS);
	localparam int PIX_CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int CNT_W     = 16;
	localparam int DELAY_W   = 8;
	localparam int PPS_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [CNT_W-1:0]   START_HIGH_RST = CNT_W'(300);
	localparam logic [DELAY_W-1:0] READ_DELAY_RST = DELAY_W'(14);
	localparam logic [PPS_W-1:0]   PIXELS_RST     = PPS_W'(512);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_HIGH = 2'd0,
		CFG_READ_DELAY = 2'd1,
		CFG_PIXELS     = 2'd2
	} lsrs_cfg_idx_t;

	// input word
	typedef struct packed {
		logic                 cmd;
		logic [PIX_VAL_W-1:0] video_sample;
	} lsrs_in_t;

	// result word
	typedef struct packed {
		logic                 clock_level;
		logic                 start_level;
		logic                 pixel_valid;
		logic [PIX_VAL_W-1:0] pixel_value;
		logic [PIX_IDX_W-1:0] pixel_index;
		logic                 scan_done;
	} lsrs_out_t;

endpackage

// ===== rtl/linear_sensor_readout_sequencer_top.sv =====
// ------------------------------------------------------------------------
// linear_sensor_readout_sequencer_top
// Clock and start pulse sequencer for a linear image sensor with pixel capture.
// ------------------------------------------------------------------------
// Usage:
// in channel: one word per half sensor clock period (cmd 0) or a scan start
//   (cmd 1), with the video sample taken at that tick.
// out channel: exactly one word per input word, giving the clock and start
//   pin levels after that word, the captured pixel (value and index) when a
//   falling edge lands in the read window, and the scan done flag.
// cfg channel: writes start high length, read delay and pixels per scan by
//   index; always ready, to be used only while the block is idle.
// Pipeline: a word accepted into the input register is loaded into the result
//   register and then offered on the out channel (input register, then result
//   register). Throughput: one word per cycle while out_ready stays high, set
//   by the single pass of compare and increment logic between the two registers.
// Reset: config returns to 300 / 14 / 512, the clock pin goes high, the start
//   pin low, and the block idles with done set until a start word.
// Stall: when out_ready is low the result register holds, the input register
//   takes one more word, then in_ready drops until the receiver drains.
// ------------------------------------------------------------------------
`include "linear_sensor_readout_sequencer_top_macros.svh"

module linear_sensor_readout_sequencer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lsrs_pkg::lsrs_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lsrs_pkg::lsrs_out_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lsrs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lsrs_pkg::*;

	localparam logic [PIX_VAL_W-1:0] SAMPLE_MASK = PIX_VAL_W'((64'd1 << SAMPLE_BITS) - 64'd1);
	localparam logic [PIX_CNT_W-1:0] MAX_PIX_C   = PIX_CNT_W'(MAX_PIXELS);
	localparam logic [CNT_W-1:0]     CNT_MAX     = {CNT_W{1'b1}};

	// config registers
	logic [CNT_W-1:0]   shc_q;
	logic [DELAY_W-1:0] rd_q;
	logic [PPS_W-1:0]   pps_q;

	// sequencer state
	logic [CNT_W-1:0]     cnt_q;
	logic                 rise_q;
	logic [PIX_CNT_W-1:0] pix_cnt_q;
	logic                 clk_pin_q;
	logic                 start_pin_q;
	logic                 done_q;

	// pipeline registers
	logic      valid_s1;
	lsrs_in_t  in_s1;
	logic      out_valid_q;
	lsrs_out_t out_q;

	// next-state values
	logic [CNT_W-1:0]     cnt_d;
	logic                 rise_d;
	logic [PIX_CNT_W-1:0] pix_cnt_d;
	logic                 clk_pin_d;
	logic                 start_pin_d;
	logic                 done_d;
	lsrs_out_t            res_d;
	logic [CNT_W:0]       read_point;
	logic [PIX_CNT_W-1:0] scan_len;
	logic                 advance;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shc_q <= START_HIGH_RST;
			rd_q  <= READ_DELAY_RST;
			pps_q <= PIXELS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_START_HIGH: shc_q <= cfg_data;
				CFG_READ_DELAY: rd_q  <= cfg_data[DELAY_W-1:0];
				CFG_PIXELS:     pps_q <= cfg_data[PPS_W-1:0];
				default:        ;
			endcase
		end
	end

	// scan length clamped to one .. max pixels
	always_comb begin
		if (32'(pps_q) > 32'(MAX_PIXELS))
			scan_len = MAX_PIX_C;
		else if (pps_q == '0)
			scan_len = PIX_CNT_W'(1);
		else
			scan_len = PIX_CNT_W'(pps_q);
	end

	assign read_point = {1'b0, shc_q} + {{(CNT_W + 1 - DELAY_W){1'b0}}, rd_q};

	// one word through the sequencer
	always_comb begin
		cnt_d       = cnt_q;
		rise_d      = rise_q;
		pix_cnt_d   = pix_cnt_q;
		clk_pin_d   = clk_pin_q;
		start_pin_d = start_pin_q;
		done_d      = done_q;
		res_d       = '0;
		if (in_s1.cmd) begin
			cnt_d     = '0;
			rise_d    = 1'b0;
			pix_cnt_d = '0;
			clk_pin_d = 1'b1;
			done_d    = 1'b0;
		end else if (!done_q) begin
			// start pulse edges seen before the count moves
			if (cnt_q == '0)
				start_pin_d = 1'b1;
			else if (cnt_q == shc_q)
				start_pin_d = 1'b0;
			if (rise_q) begin
				clk_pin_d = 1'b1;
			end else begin
				clk_pin_d = 1'b0;
				if (cnt_q != CNT_MAX)
					cnt_d = cnt_q + CNT_W'(1);
				// falling edge inside the read window captures a pixel
				if ({1'b0, cnt_d} >= read_point) begin
					res_d.pixel_valid = 1'b1;
					res_d.pixel_value = in_s1.video_sample & SAMPLE_MASK;
					res_d.pixel_index = pix_cnt_q[PIX_IDX_W-1:0];
					pix_cnt_d         = pix_cnt_q + PIX_CNT_W'(1);
					if (pix_cnt_d >= scan_len) begin
						done_d      = 1'b1;
						start_pin_d = 1'b1;
						clk_pin_d   = 1'b1;
					end
				end
			end
			rise_d = !rise_q;
		end
		res_d.clock_level = clk_pin_d;
		res_d.start_level = start_pin_d;
		res_d.scan_done   = done_d;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			in_s1 <= in_data;
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rise_q      <= 1'b0;
			pix_cnt_q   <= '0;
			clk_pin_q   <= 1'b1;
			start_pin_q <= 1'b0;
			done_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			cnt_q       <= cnt_d;
			rise_q      <= rise_d;
			pix_cnt_q   <= pix_cnt_d;
			clk_pin_q   <= clk_pin_d;
			start_pin_q <= start_pin_d;
			done_q      <= done_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res_d;
	end

	// checks
	`LSRS_ASSERT_NOW(a_pix_cnt_range, 1'b1, pix_cnt_q <= MAX_PIX_C)
	`LSRS_ASSERT_NOW(a_idle_fields_zero, out_valid_q && !out_q.pixel_valid,
		out_q.pixel_value == '0 && out_q.pixel_index == '0)
	`LSRS_ASSERT_NOW(a_capture_on_fall, out_valid_q && out_q.pixel_valid && !out_q.scan_done,
		!out_q.clock_level)
	`LSRS_ASSERT_NEXT(a_done_pins_high, advance && !done_q && done_d,
		clk_pin_q && start_pin_q && out_q.pixel_valid)

endmodule

// ===== sim/tb_linear_sensor_readout_sequencer_top.sv =====
// ------------------------------------------------------------------------
// tb_linear_sensor_readout_sequencer_top
// Self-checking bench for the sensor readout sequencer. A behavioral model
// of the sensor pin sequence is updated on every accepted input word. Each
// result word is checked field by field against the oldest pending
// prediction. The sender works in bursts with gaps between them, and the
// receiver stalls on patterns of its own. Directed scans cover the reset
// setting, short and zero settings, restarts, the longest read delay and a
// read point past the count range; random scans follow.
// ------------------------------------------------------------------------
module tb_linear_sensor_readout_sequencer_top;
	import lsrs_pkg::*;

	localparam int LIMIT_CYCLES  = 100_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_WORDS  = 250;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	lsrs_in_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	lsrs_out_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// sequencer model: registers
	logic [CNT_W-1:0]   start_high_len;
	logic [DELAY_W-1:0] read_delay_len;
	logic [PPS_W-1:0]   scan_pixels;

	// sequencer model: scan state
	logic [CNT_W-1:0]   clk_count;
	logic               rise_next;
	logic [PPS_W-1:0]   pix_count;
	logic               clk_pin;
	logic               start_pin;
	logic               scan_over;

	lsrs_out_t pending_pin_words[$];
	int        errors;
	int        cycles;
	int        burst_left;

	linear_sensor_readout_sequencer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// next pin levels and captured pixel for one input word
	function automatic lsrs_out_t sequencer_step(input logic cmd,
			input logic [PIX_VAL_W-1:0] sample);
		lsrs_out_t w;
		int        read_at;
		int        scan_len;
		w        = '0;
		read_at  = int'(start_high_len) + int'(read_delay_len);
		scan_len = (scan_pixels > MAX_PIXELS) ? MAX_PIXELS : int'(scan_pixels);
		if (scan_len == 0)
			scan_len = 1;
		if (cmd) begin
			clk_count = '0;
			rise_next = 1'b0;
			pix_count = '0;
			clk_pin   = 1'b1;
			scan_over = 1'b0;
		end else if (!scan_over) begin
			if (clk_count == '0)
				start_pin = 1'b1;
			else if (clk_count == start_high_len)
				start_pin = 1'b0;
			if (rise_next) begin
				clk_pin = 1'b1;
			end else begin
				clk_pin = 1'b0;
				if (clk_count != '1)
					clk_count++;
				// falling edge inside the read window
				if (int'(clk_count) >= read_at) begin
					w.pixel_valid = 1'b1;
					w.pixel_value = sample;
					w.pixel_index = pix_count[PIX_IDX_W-1:0];
					pix_count++;
					if (int'(pix_count) >= scan_len) begin
						scan_over = 1'b1;
						start_pin = 1'b1;
						clk_pin   = 1'b1;
					end
				end
			end
			rise_next = ~rise_next;
		end
		w.clock_level = clk_pin;
		w.start_level = start_pin;
		w.scan_done   = scan_over;
		return w;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin : check_words
		lsrs_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pin_words.size() == 0) begin
				$display("%0t: unexpected word expected none actual %h", $time, out_data);
				errors++;
			end else begin
				want = pending_pin_words.pop_front();
				check_field("clock_level", want.clock_level, out_data.clock_level);
				check_field("start_level", want.start_level, out_data.start_level);
				check_field("pixel_valid", want.pixel_valid, out_data.pixel_valid);
				check_field("pixel_value", want.pixel_value, out_data.pixel_value);
				check_field("pixel_index", want.pixel_index, out_data.pixel_index);
				check_field("scan_done", want.scan_done, out_data.scan_done);
			end
		end
	end

	// receiver stall patterns
	initial begin : receiver
		int mode;
		int left;
		int stall;
		mode      = 0;
		left      = 0;
		stall     = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 300);
			end
			left--;
			case (mode)
				0: out_ready = 1'b1;
				1: out_ready = ($urandom_range(0, 9) >= 3);
				2: out_ready = ~out_ready;
				default: begin
					if (stall > 0) begin
						out_ready = 1'b0;
						stall--;
					end else begin
						out_ready = 1'b1;
						if ($urandom_range(0, 7) == 0)
							stall = $urandom_range(1, 8);
					end
				end
			endcase
		end
	end

	// send one input word, entered and left at a falling edge
	task automatic send_word(input logic cmd, input logic [PIX_VAL_W-1:0] sample);
		in_data.cmd          = cmd;
		in_data.video_sample = sample;
		in_valid             = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_pin_words.push_back(sequencer_step(cmd, sample));
		@(negedge clk);
		in_valid = 1'b0;
		// burst and gap pacing
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, 4)) @(negedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_reg(input lsrs_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_START_HIGH: start_high_len = data[CNT_W-1:0];
			CFG_READ_DELAY: read_delay_len = data[DELAY_W-1:0];
			CFG_PIXELS:     scan_pixels    = data[PPS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait until every predicted word has come back and the block is quiet
	task automatic wait_idle();
		while (pending_pin_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(input int high_len, input int delay, input int pixels);
		wait_idle();
		write_reg(CFG_START_HIGH, CFG_DATA_W'(high_len));
		write_reg(CFG_READ_DELAY, CFG_DATA_W'(delay));
		write_reg(CFG_PIXELS, CFG_DATA_W'(pixels));
	endtask

	task automatic tick_until_done(input int max_ticks);
		int n;
		n = 0;
		while (!scan_over && n < max_ticks) begin
			send_word(1'b0, PIX_VAL_W'($urandom_range(0, 1023)));
			n++;
		end
	endtask

	// ticks before any start are ignored
	task automatic test_idle_after_reset();
		send_word(1'b0, 10'h000);
		send_word(1'b0, 10'h3FF);
	endtask

	// scan at the reset register values, through start low and the first pixels
	task automatic test_reset_scan();
		send_word(1'b1, 10'h3FF);
		tick_until_done(640);
	endtask

	// shortest read point with extreme samples, ticks after done
	task automatic test_short_scan();
		int n;
		n = 0;
		set_config(1, 0, 3);
		send_word(1'b1, 10'h000);
		while (!scan_over) begin
			send_word(1'b0, n[0] ? 10'h3FF : 10'h000);
			n++;
		end
		send_word(1'b0, 10'h3FF);
		send_word(1'b0, 10'h000);
	endtask

	// start high length zero and pixel count zero
	task automatic test_zero_start_high();
		set_config(0, 2, 0);
		send_word(1'b1, 10'h2AA);
		tick_until_done(100);
	endtask

	// start word in the middle of a scan, and two starts back to back
	task automatic test_restart_mid_scan();
		set_config(2, 1, 5);
		send_word(1'b1, 10'h001);
		repeat (7) send_word(1'b0, PIX_VAL_W'($urandom_range(0, 1023)));
		send_word(1'b1, 10'h200);
		send_word(1'b1, 10'h100);
		tick_until_done(100);
	endtask

	// longest read delay
	task automatic test_max_delay();
		set_config(1, 255, 2);
		send_word(1'b1, 10'h000);
		tick_until_done(1000);
	endtask

	// read point past the count range must never capture
	task automatic test_read_window_wrap();
		set_config(16'hFFFF, 255, 4);
		send_word(1'b1, 10'h000);
		repeat (60) send_word(1'b0, PIX_VAL_W'($urandom_range(0, 1023)));
		set_config(65400, 200, 4);
		send_word(1'b1, 10'h000);
		repeat (60) send_word(1'b0, PIX_VAL_W'($urandom_range(0, 1023)));
	endtask

	// random settings, mostly complete scans with some aborted ones
	task automatic test_random();
		int words;
		int sel;
		int scans;
		int abort_at;
		int max_ticks;
		int n;
		words = 0;
		while (words < RANDOM_WORDS) begin
			sel       = $urandom_range(0, 9);
			max_ticks = 100;
			if (sel < 7) begin
				set_config($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 10));
			end else if (sel == 7) begin
				set_config($urandom_range(1, 12), $urandom_range(0, 12), $urandom_range(1, 16));
			end else if (sel == 8) begin
				set_config($urandom_range(0, 3), $urandom_range(0, 2),
					$urandom_range(0, 24));
			end else begin
				set_config($urandom_range(65300, 65535), $urandom_range(200, 255),
					$urandom_range(1, 4));
				max_ticks = 30;
			end
			scans = $urandom_range(1, 4);
			repeat (scans) begin
				send_word(1'b1, PIX_VAL_W'($urandom_range(0, 1023)));
				words++;
				abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : -1;
				n = 0;
				while (!scan_over && n < max_ticks) begin
					send_word(n == abort_at, PIX_VAL_W'($urandom_range(0, 1023)));
					n++;
					words++;
				end
				// noise ticks, ignored once the scan is over
				repeat ($urandom_range(0, 2))
					send_word(1'b0, PIX_VAL_W'($urandom_range(0, 1023)));
			end
		end
	endtask

	// reset and test sequence
	initial begin
		errors         = 0;
		burst_left     = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_START_HIGH;
		cfg_data       = '0;
		start_high_len = START_HIGH_RST;
		read_delay_len = READ_DELAY_RST;
		scan_pixels    = PIXELS_RST;
		clk_count      = '0;
		rise_next      = 1'b0;
		pix_count      = '0;
		clk_pin        = 1'b1;
		start_pin      = 1'b0;
		scan_over      = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_after_reset();
		test_reset_scan();
		test_short_scan();
		test_zero_start_high();
		test_restart_mid_scan();
		test_max_delay();
		test_read_window_wrap();
		test_random();

		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_pin_words.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
